[hdl/msort_pkg.sv]
// ----------------------------------------------------------------------------
// msort_pkg: shared types and constants of the merge sorter
// Sequencer states, data width and the per-transfer result budget.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msort_pkg;

  localparam int DATA_W           = 32;
  localparam int RESULTS_PER_STEP = 64;
  localparam int BUDGET_W         = $clog2(RESULTS_PER_STEP + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN_PRE,
    ST_LOAD,
    ST_RUN_INIT,
    ST_RUN_LOAD,
    ST_MERGE,
    ST_DRAIN_POST
  } state_t;

endpackage

[hdl/merge_sorter.sv]
// ----------------------------------------------------------------------------
// merge_sorter: stable ascending bottom-up merge sort of signed 32-bit sets
// Load: each transfer first drains pending results, then loads its value.
// Sort: ceil(log2 N) passes over the two stores, plus one more copy pass
//   when the pass count is even (N = set size).
// Output: scratch store, one result per cycle unless stalled, up to 64/transfer.
// Reset: synchronous; clears count, pending results and handshake state only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module merge_sorter #(
  parameter int MAX_ITEMS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [msort_pkg::DATA_W-1:0]  value,
  input  logic                                 last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [msort_pkg::DATA_W-1:0]  sorted_value,
  output logic                                 last_out,
  output logic                                 overflow
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int WW = CW + 3;
  localparam int DW = msort_pkg::DATA_W;
  localparam int BW = msort_pkg::BUDGET_W;

  msort_pkg::state_t state, state_next;

  logic signed [DW-1:0] element_store [MAX_ITEMS];
  logic signed [DW-1:0] scratch_store [MAX_ITEMS];

  logic signed [DW-1:0] elem_rda, elem_rdb, scr_rda, scr_rdb;
  logic signed [DW-1:0] rda, rdb, ha, hb, in_value, wdata;

  logic [CW-1:0] element_count, sort_n, lo, mid, hi, a, b, k;
  logic [CW-1:0] out_left, out_pos, ptr_a, ptr_b, mid_calc, hi_calc;
  logic [WW-1:0] w, w_dbl, lo_step, rem;
  logic [BW-1:0] n_emit;
  logic          in_last, overflow_seen, ovf_set, out_ovf, src_sel;
  logic          p1, p1_last, p1_ovf;

  logic draining, can_emit, drain_issue, drain_done, out_move;
  logic a_ok, b_ok, take_a, run_done, pass_done, sort_done;
  logic mem_re, merge_we, room;

  assign in_ready = (state == msort_pkg::ST_IDLE);
  assign room     = (element_count < CW'(MAX_ITEMS));

  assign rda = src_sel ? scr_rda : elem_rda;
  assign rdb = src_sel ? scr_rdb : elem_rdb;

  assign rem      = WW'(sort_n) - WW'(lo);
  assign mid_calc = (rem > w) ? CW'(WW'(lo) + w) : sort_n;
  assign hi_calc  = (rem > (w << 1)) ? CW'(WW'(lo) + (w << 1)) : sort_n;

  assign w_dbl     = w << 1;
  assign lo_step   = WW'(lo) + w_dbl;
  assign a_ok      = (a < mid);
  assign b_ok      = (b < hi);
  assign take_a    = a_ok && (!b_ok || (ha <= hb));
  assign run_done  = (state == msort_pkg::ST_MERGE) && !a_ok && !b_ok;
  assign pass_done = (lo_step >= WW'(sort_n));
  assign sort_done = pass_done && (w_dbl >= WW'(sort_n)) && !src_sel;
  assign wdata     = take_a ? ha : hb;
  assign merge_we  = (state == msort_pkg::ST_MERGE) && !run_done;

  assign draining    = (state == msort_pkg::ST_DRAIN_PRE) ||
                       (state == msort_pkg::ST_DRAIN_POST);
  assign out_move    = p1 && (!out_valid || out_ready);
  assign can_emit    = (out_left != '0) && (n_emit != BW'(msort_pkg::RESULTS_PER_STEP));
  assign drain_issue = draining && can_emit && (!p1 || out_move);
  assign drain_done  = draining && !can_emit && !p1;

  always_comb begin
    state_next = state;
    ptr_a      = out_pos;
    ptr_b      = b;
    mem_re     = 1'b0;
    case (state)
      msort_pkg::ST_IDLE: begin
        if (in_valid) state_next = msort_pkg::ST_DRAIN_PRE;
      end
      msort_pkg::ST_DRAIN_PRE: begin
        if (drain_done) state_next = msort_pkg::ST_LOAD;
      end
      msort_pkg::ST_LOAD: begin
        state_next = in_last ? msort_pkg::ST_RUN_INIT : msort_pkg::ST_IDLE;
      end
      msort_pkg::ST_RUN_INIT: begin
        ptr_a      = lo;
        ptr_b      = mid_calc;
        mem_re     = 1'b1;
        state_next = msort_pkg::ST_RUN_LOAD;
      end
      msort_pkg::ST_RUN_LOAD: begin
        ptr_a      = a + CW'(1);
        ptr_b      = b + CW'(1);
        mem_re     = 1'b1;
        state_next = msort_pkg::ST_MERGE;
      end
      msort_pkg::ST_MERGE: begin
        ptr_a  = take_a ? a + CW'(2) : a + CW'(1);
        ptr_b  = take_a ? b + CW'(1) : b + CW'(2);
        mem_re = 1'b1;
        if (run_done) begin
          state_next = sort_done ? msort_pkg::ST_DRAIN_POST : msort_pkg::ST_RUN_INIT;
        end
      end
      msort_pkg::ST_DRAIN_POST: begin
        if (drain_done) state_next = msort_pkg::ST_IDLE;
      end
      default: state_next = msort_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= msort_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // element store: load writes, merge writes when it is the destination
  always_ff @(posedge clk) begin
    if (state == msort_pkg::ST_LOAD && room) begin
      element_store[element_count[AW-1:0]] <= in_value;
    end else if (merge_we && src_sel) begin
      element_store[k[AW-1:0]] <= wdata;
    end
    if (mem_re) begin
      elem_rda <= element_store[ptr_a[AW-1:0]];
      elem_rdb <= element_store[ptr_b[AW-1:0]];
    end
  end

  // scratch store: merge destination and output buffer
  always_ff @(posedge clk) begin
    if (merge_we && !src_sel) begin
      scratch_store[k[AW-1:0]] <= wdata;
    end
    if (mem_re || drain_issue) begin
      scr_rda <= scratch_store[ptr_a[AW-1:0]];
    end
    if (mem_re) begin
      scr_rdb <= scratch_store[ptr_b[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
      overflow_seen <= 1'b0;
      out_left      <= '0;
      out_pos       <= '0;
      out_ovf       <= 1'b0;
      n_emit        <= '0;
      p1            <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (drain_issue) begin
        p1 <= 1'b1;
      end else if (out_move) begin
        p1 <= 1'b0;
      end
      if (out_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        msort_pkg::ST_IDLE: begin
          if (in_valid) n_emit <= '0;
        end
        msort_pkg::ST_DRAIN_PRE, msort_pkg::ST_DRAIN_POST: begin
          if (drain_issue) begin
            out_pos  <= out_pos + CW'(1);
            out_left <= out_left - CW'(1);
            n_emit   <= n_emit + BW'(1);
          end
        end
        msort_pkg::ST_LOAD: begin
          if (in_last) begin
            element_count <= '0;
            overflow_seen <= 1'b0;
          end else if (room) begin
            element_count <= element_count + CW'(1);
          end else begin
            overflow_seen <= 1'b1;
          end
        end
        msort_pkg::ST_MERGE: begin
          if (run_done && sort_done) begin
            out_left <= sort_n;
            out_pos  <= '0;
            out_ovf  <= ovf_set;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_value <= value;
      in_last  <= last;
    end
    if (drain_issue) begin
      p1_last <= (out_left == CW'(1));
      p1_ovf  <= out_ovf;
    end
    if (out_move) begin
      sorted_value <= scr_rda;
      last_out     <= p1_last;
      overflow     <= p1_ovf;
    end
    case (state)
      msort_pkg::ST_LOAD: begin
        if (in_last) begin
          sort_n  <= room ? element_count + CW'(1) : element_count;
          ovf_set <= overflow_seen || !room;
          w       <= WW'(1);
          lo      <= '0;
          src_sel <= 1'b0;
        end
      end
      msort_pkg::ST_RUN_INIT: begin
        mid <= mid_calc;
        hi  <= hi_calc;
        a   <= lo;
        b   <= mid_calc;
        k   <= lo;
      end
      msort_pkg::ST_RUN_LOAD: begin
        ha <= rda;
        hb <= rdb;
      end
      msort_pkg::ST_MERGE: begin
        if (!run_done) begin
          k <= k + CW'(1);
          if (take_a) begin
            a  <= a + CW'(1);
            ha <= rda;
          end else begin
            b  <= b + CW'(1);
            hb <= rdb;
          end
        end else if (pass_done) begin
          src_sel <= ~src_sel;
          w       <= w_dbl;
          lo      <= '0;
        end else begin
          lo <= CW'(lo_step);
        end
      end
      default: begin
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    state == msort_pkg::ST_MERGE |-> (a <= mid) && (b <= hi))
    else $error("merge pointer ran past its run");

  assert property (@(posedge clk) disable iff (rst)
    state == msort_pkg::ST_MERGE |-> (k + mid) == (a + b))
    else $error("merge write pointer out of step with read pointers");

  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !p1)
    else $error("read still in flight while taking a transfer");

  assert property (@(posedge clk) disable iff (rst)
    n_emit <= BW'(msort_pkg::RESULTS_PER_STEP))
    else $error("result budget exceeded");

  assert property (@(posedge clk) disable iff (rst)
    element_count <= CW'(MAX_ITEMS))
    else $error("element count beyond capacity");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the merge sorter
// Feeds sets of signed values over the input handshake and checks each sorted
// result against a stable ascending sort kept in the bench: order, last flag
// and the truncation flag. Covers extremes, ties, long sets that release over
// several transfers, a truncated set and a new set that cuts off a drain.
// Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int SET_CAP    = 256;
  localparam int RAND_ITEMS = 20;

  typedef logic signed [msort_pkg::DATA_W-1:0] word_t;

  typedef struct {
    word_t value;
    logic  last;
    logic  ovf;
  } result_t;

  typedef struct {
    word_t   value;
    logic    last;
    bit      typed;
    result_t result;
  } stim_row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_BLOCKED
  } rx_mode_t;

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  word_t value     = '0;
  logic  last      = 1'b0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  word_t sorted_value;
  logic  last_out;
  logic  overflow;

  merge_sorter #(
    .MAX_ITEMS(SET_CAP)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .value       (value),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sorted_value(sorted_value),
    .last_out    (last_out),
    .overflow    (overflow)
  );

  always #10 clk = ~clk;

  // sorter state as seen from outside
  word_t       load_buf   [SET_CAP];
  word_t       sorted_buf [SET_CAP];
  int unsigned load_count = 0;
  bit          load_ovf   = 1'b0;
  int unsigned pend_left  = 0;
  int unsigned pend_pos   = 0;
  bit          pend_ovf   = 1'b0;

  result_t   expected_sorted [$];
  stim_row_t sent_rows [$];
  logic      in_took    = 1'b0;
  int        fail_count = 0;
  int        burst_left = 0;

  stim_row_t directed_rows [20] = '{
    '{32'sh7FFFFFFF, 1'b1, 1'b1, '{32'sh7FFFFFFF, 1'b1, 1'b0}},
    '{32'sh80000000, 1'b1, 1'b1, '{32'sh80000000, 1'b1, 1'b0}},
    '{32'sd0,        1'b1, 1'b1, '{32'sd0,        1'b1, 1'b0}},
    '{-32'sd1,       1'b1, 1'b1, '{-32'sd1,       1'b1, 1'b0}},
    '{32'sd5,        1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{-32'sd3,       1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{32'sh7FFFFFFF, 1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{32'sh80000000, 1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{-32'sd3,       1'b1, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{32'sd1,        1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{-32'sd1,       1'b1, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{32'sd7,        1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{32'sd7,        1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{32'sd7,        1'b1, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{32'sd4,        1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{32'sd3,        1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{32'sd2,        1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{32'sd1,        1'b0, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{32'sd0,        1'b1, 1'b0, '{32'sd0, 1'b0, 1'b0}},
    '{32'sd12345,    1'b1, 1'b1, '{32'sd12345,    1'b1, 1'b0}}
  };

  task automatic release_pending(inout int budget, input bit keep);
    while (pend_left > 0 && budget > 0) begin
      if (keep) begin
        expected_sorted.push_back('{sorted_buf[pend_pos], pend_left == 1, pend_ovf});
      end
      pend_pos++;
      pend_left--;
      budget--;
    end
  endtask

  task automatic sort_loaded_set();
    word_t key;
    int    j;
    for (int i = 0; i < load_count; i++) sorted_buf[i] = load_buf[i];
    for (int i = 1; i < load_count; i++) begin
      key = sorted_buf[i];
      j   = i - 1;
      while (j >= 0) begin
        if (sorted_buf[j] <= key) break;
        sorted_buf[j + 1] = sorted_buf[j];
        j--;
      end
      sorted_buf[j + 1] = key;
    end
  endtask

  task automatic advance_sorted_stream(input word_t v, input logic lst, input bit keep);
    int budget;
    budget = msort_pkg::RESULTS_PER_STEP;
    release_pending(budget, keep);
    if (load_count < SET_CAP) begin
      load_buf[load_count] = v;
      load_count++;
    end else begin
      load_ovf = 1'b1;
    end
    if (lst) begin
      sort_loaded_set();
      pend_left  = load_count;
      pend_pos   = 0;
      pend_ovf   = load_ovf;
      load_count = 0;
      load_ovf   = 1'b0;
      release_pending(budget, keep);
    end
  endtask

  function automatic word_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return word_t'($urandom);
    if (r < 80) return word_t'($urandom_range(0, 15) - 8);
    case ($urandom_range(0, 3))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic send_row(input stim_row_t row);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    sent_rows.push_back(row);
    in_valid <= 1'b1;
    value    <= row.value;
    last     <= row.last;
    do @(negedge clk); while (!in_took);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_sorted.size() != 0);
  endtask

  always @(posedge clk) begin : scoreboard
    stim_row_t row;
    result_t   want;
    in_took <= in_valid && in_ready && !rst;
    if (!rst) begin
      if (in_valid && in_ready) begin
        row = sent_rows.pop_front();
        advance_sorted_stream(row.value, row.last, !row.typed);
        if (row.typed) expected_sorted.push_back(row.result);
      end
      if (out_valid && out_ready) begin
        if (expected_sorted.size() == 0) begin
          $error("sorted_value: expected none, got %0d", sorted_value);
          fail_count++;
        end else begin
          want = expected_sorted.pop_front();
          if (sorted_value !== want.value) begin
            $error("sorted_value: expected %0d, got %0d", want.value, sorted_value);
            fail_count++;
          end
          if (last_out !== want.last) begin
            $error("last_out: expected %0b, got %0b", want.last, last_out);
            fail_count++;
          end
          if (overflow !== want.ovf) begin
            $error("overflow: expected %0b, got %0b", want.ovf, overflow);
            fail_count++;
          end
        end
      end
    end
  end

  rx_mode_t rx_mode  = RX_OPEN;
  logic [7:0] rx_cycle = '0;
  int rx_hold = 0;

  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    if (rx_cycle[5:0] == 6'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    if (rx_hold > 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= (rx_cycle[1:0] == 2'd0);
        default: begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 15) == 0) rx_hold <= $urandom_range(5, 30);
        end
      endcase
    end
  end

  initial begin : stimulus
    stim_row_t row;
    int        sent;
    int        set_len;
    int        r;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) send_row(directed_rows[i]);
    wait_drained();

    // truncated set, then two one-value sets; the first cuts off its drain
    row.typed  = 1'b0;
    row.result = '{32'sd0, 1'b0, 1'b0};
    for (int k = 0; k < SET_CAP + 2; k++) begin
      row.value = pick_value();
      row.last  = (k == SET_CAP + 1);
      send_row(row);
    end
    for (int k = 0; k < 2; k++) begin
      row.value = pick_value();
      row.last  = 1'b1;
      send_row(row);
    end
    wait_drained();

    sent = 0;
    while (sent < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 60)      set_len = $urandom_range(1, 6);
      else if (r < 92) set_len = $urandom_range(7, 30);
      else             set_len = $urandom_range(65, 120);
      if (set_len > RAND_ITEMS - sent) set_len = RAND_ITEMS - sent;
      for (int k = 0; k < set_len; k++) begin
        row.value = pick_value();
        row.last  = (k == set_len - 1);
        send_row(row);
      end
      sent += set_len;
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    repeat (64) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #(10_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
